// ===== design/csr_pkg.sv =====
// Shared constants, types and helpers for the controller smoothing ramp block.
// Used by the divider, the multiply-accumulate unit, the table and the top level.
// No dependencies.
package csr_pkg;

	// Default sizes for the top-level parameters.
	localparam int DEF_BLOCK_SAMPLES = 32;
	localparam int DEF_TABLE_SIZE    = 1024;

	// Fixed field widths.
	localparam int CTL_W     = 7;
	localparam int DATA_W    = 32;
	localparam int SKIP_W    = 6;
	localparam int ADDR_W    = 10;
	localparam int COEFF_W   = 16;
	localparam int CFG_IDX_W = 1;

	// Divider: 32-bit dividend, divisor up to 127, two quotient bits per cycle.
	localparam int DIV_N_W = 32;
	localparam int DIV_D_W = 7;

	// Wide enough for any skip field and for block lengths up to 127.
	localparam int CNT_W = 7;

	// Multiply-accumulate widths.
	localparam int MAC_A_W = 33;
	localparam int MAC_B_W = 18;
	localparam int MAC_P_W = MAC_A_W + MAC_B_W;
	localparam int ACC_W   = 66;

	// Full-scale controller value, the divisor of the normalization.
	localparam logic [DIV_D_W-1:0] CTL_SPAN = 7'd127;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_COEFF     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_TABLE = 1'b1;

	// Request kinds.
	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_TABLE = 1'b1;

	typedef struct packed {
		logic en;
		logic clr;
		logic shl;
	} mac_ctl_t;

	// Saturate a wide signed value to signed 32 bits.
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-DATA_W:0] top_bits;
		top_bits = v[ACC_W-1:DATA_W-1];
		if (top_bits == '0 || top_bits == '1) begin
			return v[DATA_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

// ===== design/csr_div.sv =====
// Radix-4 restoring divider: 32-bit unsigned dividend by a 7-bit divisor.
// Two quotient bits per cycle.
// Depends on csr_pkg for widths.
module csr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [csr_pkg::DIV_N_W-1:0]   dividend,
	input  logic [csr_pkg::DIV_D_W-1:0]   divisor,
	output logic                          busy,
	output logic [csr_pkg::DIV_N_W-1:0]   quot,
	output logic [csr_pkg::DIV_D_W-1:0]   rem
);

	localparam int STEPS = csr_pkg::DIV_N_W / 2;
	localparam int SW    = $clog2(STEPS);
	localparam int RW    = csr_pkg::DIV_D_W + 1;

	logic                        busy_q;
	logic [SW-1:0]               cnt_q;
	logic [csr_pkg::DIV_N_W-1:0] quo_q;
	logic [csr_pkg::DIV_D_W-1:0] rem_q;
	logic [csr_pkg::DIV_D_W-1:0] den_q;

	logic [RW-1:0] den_ext;
	logic [RW-1:0] r1, r1n, r2, r2n;
	logic          ge1, ge2;

	always_comb begin
		den_ext = {1'b0, den_q};
		r1      = {rem_q, quo_q[csr_pkg::DIV_N_W-1]};
		ge1     = r1 >= den_ext;
		r1n     = ge1 ? r1 - den_ext : r1;
		r2      = {r1n[csr_pkg::DIV_D_W-1:0], quo_q[csr_pkg::DIV_N_W-2]};
		ge2     = r2 >= den_ext;
		r2n     = ge2 ? r2 - den_ext : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == SW'(STEPS - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[csr_pkg::DIV_N_W-3:0], ge1, ge2};
			rem_q <= r2n[csr_pkg::DIV_D_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ===== design/csr_mac.sv =====
// Shared signed multiply-accumulate unit: registered 33x18 product, then a
// 66-bit accumulator that can clear and can weight the product by 2^16.
// Depends on csr_pkg for widths and the control struct.
module csr_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  csr_pkg::mac_ctl_t                   ctl,
	input  logic signed [csr_pkg::MAC_A_W-1:0]  op_a,
	input  logic signed [csr_pkg::MAC_B_W-1:0]  op_b,
	output logic signed [csr_pkg::ACC_W-1:0]    acc
);

	csr_pkg::mac_ctl_t                   ctl_s1;
	logic signed [csr_pkg::MAC_P_W-1:0]  prod_s1;
	logic signed [csr_pkg::ACC_W-1:0]    acc_q;
	logic signed [csr_pkg::ACC_W-1:0]    prod_ext;
	logic signed [csr_pkg::ACC_W-1:0]    addend;

	always_comb begin
		prod_ext = csr_pkg::ACC_W'(prod_s1);
		addend   = ctl_s1.shl ? (prod_ext <<< 16) : prod_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		if (ctl_s1.en) begin
			acc_q <= (ctl_s1.clr ? '0 : acc_q) + addend;
		end
	end

	assign acc = acc_q;

endmodule

// ===== design/csr_table.sv =====
// Shaping table memory: one write port and one registered read port.
// Contents are undefined until written.
// Depends on csr_pkg for the data width.
module csr_table #(
	parameter int TABLE_SIZE = csr_pkg::DEF_TABLE_SIZE,
	localparam int AW = $clog2(TABLE_SIZE)
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [AW-1:0]                      waddr,
	input  logic signed [csr_pkg::DATA_W-1:0]  wdata,
	input  logic                               re,
	input  logic [AW-1:0]                      raddr,
	output logic signed [csr_pkg::DATA_W-1:0]  rdata
);

	logic signed [csr_pkg::DATA_W-1:0] mem [TABLE_SIZE];
	logic signed [csr_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/controller_smoothing_ramp_core.sv =====
// Top level of the controller smoothing ramp: sequencer, output register and
// the instances of the divider, the multiply-accumulate unit and the table.
// Depends on csr_pkg, csr_div, csr_mac and csr_table.
//
// Usage. Requests enter on in_valid/in_ready. A table-write request stores
// table_data at table_addr (addresses at or beyond the table size are
// dropped) and produces nothing. A tick request maps ctl_value to a level
// (value/127 in Q16.16, or a shaping table word when use_table is set), scales
// it into [range_low, range_high], runs it through the one-pole lowpass and
// then emits BLOCK_SAMPLES samples on out_valid/out_ready, the last one
// flagged by last_sample. Samples in the lead and tail regions are zero; the
// ones between form a linear ramp from the previous level to the new one.
// Sequence. A tick passes through the accepting cycle, a division on the shared
// divider for the level, the shared multiply-accumulate unit for the scaling and
// the filter, a ramp set-up step, a second division for the ramp slope and the
// emit phase, one sample per cycle while the receiver takes them. A table lookup
// adds a read step; a block with no ramp region skips the second division.
// in_ready is high only while the sequencer is idle.
// Stalls. Samples leave through a single output register; a stalled receiver
// holds the sequencer in the emit phase, and the next request is taken as
// soon as the last sample sits in that register.
// Reset. arst_n clears the filter state, the ramp level and both registers;
// the table keeps no reset value and must be written before it is used.
// The user writes configuration through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module controller_smoothing_ramp_core #(
	parameter int BLOCK_SAMPLES = csr_pkg::DEF_BLOCK_SAMPLES,
	parameter int TABLE_SIZE    = csr_pkg::DEF_TABLE_SIZE
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  req_type,
	input  logic [csr_pkg::CTL_W-1:0]             ctl_value,
	input  logic signed [csr_pkg::DATA_W-1:0]     range_low,
	input  logic signed [csr_pkg::DATA_W-1:0]     range_high,
	input  logic [csr_pkg::SKIP_W-1:0]            lead_skip,
	input  logic [csr_pkg::SKIP_W-1:0]            tail_skip,
	input  logic [csr_pkg::ADDR_W-1:0]            table_addr,
	input  logic signed [csr_pkg::DATA_W-1:0]     table_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [csr_pkg::DATA_W-1:0]     sample,
	output logic                                  last_sample,
	input  logic                                  cfg_we,
	input  logic [csr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [csr_pkg::COEFF_W-1:0]           cfg_data
);

	localparam int CW         = $clog2(BLOCK_SAMPLES + 1);
	localparam int AW         = $clog2(TABLE_SIZE);
	localparam int TABLE_LAST = TABLE_SIZE - 1;
	localparam int DW         = csr_pkg::DATA_W;
	localparam int RW         = csr_pkg::DIV_D_W + 1;

	localparam logic signed [csr_pkg::ACC_W-1:0] ROUND_HALF = csr_pkg::ACC_W'(32768);

	typedef enum logic [3:0] {
		S_IDLE, S_LDIV, S_RD, S_MA, S_MB, S_MW, S_SC,
		S_FA, S_FB, S_FW, S_FT, S_RS, S_RDIV, S_EMIT
	} state_t;

	// Control and architectural state.
	state_t                          state_q;
	logic [csr_pkg::COEFF_W-1:0]     coeff_q;
	logic                            use_table_q;
	logic signed [DW-1:0]            fs_q;
	logic signed [DW-1:0]            ramp_q;
	logic                            out_valid_q;
	logic signed [DW-1:0]            sample_q;
	logic                            last_q;

	// Per-request datapath registers.
	logic signed [DW-1:0]            lo_q;
	logic signed [DW:0]              hd_q;
	logic signed [DW-1:0]            level_q;
	logic signed [DW-1:0]            scaled_q;
	logic [CW-1:0]                   lead_q;
	logic [CW-1:0]                   end_q;
	logic [CW-1:0]                   count_q;
	logic                            has_ramp_q;
	logic                            neg_q;
	logic [csr_pkg::DIV_N_W-1:0]     step_q;
	logic [csr_pkg::DIV_D_W-1:0]     step_rem_q;
	logic signed [DW-1:0]            ramp_acc_q;
	logic [csr_pkg::DIV_D_W-1:0]     frac_q;
	logic [CW-1:0]                   n_q;

	// Request decode.
	logic accept, tick_go, tbl_we, wr_in_range;
	logic [DW-1:0] waddr_ext;
	logic [csr_pkg::CNT_W-1:0] lead_ext, tail_ext, lead_sat, tail_sat;
	logic [CW-1:0] lead_cw, tail_cw, end_cw;
	logic [DW-1:0] tbl_num;

	// Divider hookup.
	logic                          div_start, div_busy;
	logic [csr_pkg::DIV_N_W-1:0]   div_dividend, div_quot;
	logic [csr_pkg::DIV_D_W-1:0]   div_divisor, div_rem;

	// Multiply-accumulate hookup.
	csr_pkg::mac_ctl_t                    mac_ctl;
	logic signed [csr_pkg::MAC_A_W-1:0]   mac_a;
	logic signed [csr_pkg::MAC_B_W-1:0]   mac_b;
	logic signed [csr_pkg::ACC_W-1:0]     mac_acc;
	logic signed [csr_pkg::ACC_W-1:0]     acc_shr, lo_ext, acc_rnd;
	logic signed [DW-1:0]                 scaled_next, target_next;

	// Table hookup.
	logic                  tbl_re;
	logic signed [DW-1:0]  tbl_rdata;

	// Ramp generation.
	logic signed [DW:0]    diff;
	logic [DW:0]           mag;
	logic [RW-1:0]         frac_sum, cnt_ext, frac_wrap;
	logic                  wrap;
	logic [DW-1:0]         step;
	logic signed [DW-1:0]  ramp_next;
	logic [csr_pkg::DIV_D_W-1:0] frac_next;
	logic                  emit, in_ramp, last;

	always_comb begin
		accept      = in_valid && in_ready;
		tick_go     = accept && (req_type == csr_pkg::REQ_TICK);
		waddr_ext   = DW'(table_addr);
		wr_in_range = waddr_ext < DW'(TABLE_SIZE);
		tbl_we      = accept && (req_type == csr_pkg::REQ_TABLE) && wr_in_range;

		// Skip counts saturate at the block length.
		lead_ext = csr_pkg::CNT_W'(lead_skip);
		tail_ext = csr_pkg::CNT_W'(tail_skip);
		lead_sat = (lead_ext > csr_pkg::CNT_W'(BLOCK_SAMPLES)) ?
			csr_pkg::CNT_W'(BLOCK_SAMPLES) : lead_ext;
		tail_sat = (tail_ext > csr_pkg::CNT_W'(BLOCK_SAMPLES)) ?
			csr_pkg::CNT_W'(BLOCK_SAMPLES) : tail_ext;
		lead_cw  = lead_sat[CW-1:0];
		tail_cw  = tail_sat[CW-1:0];
		end_cw   = CW'(BLOCK_SAMPLES) - tail_cw;

		// Table index numerator: value * (size - 1), divided by 127 below.
		tbl_num = DW'(ctl_value) * DW'(TABLE_LAST);

		// Distance from the old ramp level to the new filter output.
		diff = {fs_q[DW-1], fs_q} - {ramp_q[DW-1], ramp_q};
		mag  = diff[DW] ? -diff : diff;

		// The divider serves the level normalization and the ramp slope.
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = csr_pkg::CTL_SPAN;
		if (tick_go) begin
			div_start    = 1'b1;
			div_dividend = use_table_q ? tbl_num : DW'({ctl_value, 16'h0000});
		end else if (state_q == S_RS && has_ramp_q) begin
			div_start    = 1'b1;
			div_dividend = mag[DW-1:0];
			div_divisor  = csr_pkg::DIV_D_W'(count_q);
		end

		tbl_re = (state_q == S_LDIV) && !div_busy && use_table_q;

		// Operand selection for the shared multiplier. The level splits into a
		// signed upper half and an unsigned lower half so each product stays
		// within 33 by 18 bits.
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		case (state_q)
			S_MA: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, shl: 1'b0};
				mac_a   = hd_q;
				mac_b   = {2'b00, level_q[15:0]};
			end
			S_MB: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, shl: 1'b1};
				mac_a   = hd_q;
				mac_b   = {{2{level_q[DW-1]}}, level_q[DW-1:16]};
			end
			S_FA: begin
				mac_ctl = '{en: 1'b1, clr: 1'b1, shl: 1'b0};
				mac_a   = {scaled_q[DW-1], scaled_q};
				mac_b   = {1'b0, 17'h10000 - {1'b0, coeff_q}};
			end
			S_FB: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0, shl: 1'b0};
				mac_a   = {fs_q[DW-1], fs_q};
				mac_b   = {2'b00, coeff_q};
			end
			default: begin
				mac_ctl = '0;
			end
		endcase

		// Scaling takes the floor of the product over 2^16; the filter output
		// rounds half up before the same shift.
		acc_shr     = mac_acc >>> 16;
		lo_ext      = csr_pkg::ACC_W'(lo_q);
		scaled_next = csr_pkg::sat32(acc_shr + lo_ext);
		acc_rnd     = mac_acc + ROUND_HALF;
		target_next = csr_pkg::sat32(acc_rnd >>> 16);

		// Ramp stepping: the slope is |diff| = step * count + step_rem. The
		// fraction carries the remainder, so each sample adds the whole step
		// plus one when the fraction wraps past the count.
		cnt_ext   = RW'(count_q);
		frac_sum  = {1'b0, frac_q} + {1'b0, step_rem_q};
		wrap      = frac_sum >= cnt_ext;
		frac_wrap = wrap ? frac_sum - cnt_ext : frac_sum;
		frac_next = frac_wrap[csr_pkg::DIV_D_W-1:0];
		step      = step_q + DW'(wrap);
		ramp_next = neg_q ? ramp_acc_q - step : ramp_acc_q + step;

		emit    = (state_q == S_EMIT) && (!out_valid_q || out_ready);
		in_ramp = (n_q >= lead_q) && (n_q < end_q);
		last    = n_q == CW'(BLOCK_SAMPLES - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			coeff_q     <= '0;
			use_table_q <= 1'b0;
			fs_q        <= '0;
			ramp_q      <= '0;
			out_valid_q <= 1'b0;
			sample_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					csr_pkg::CFG_COEFF:     coeff_q     <= cfg_data;
					csr_pkg::CFG_USE_TABLE: use_table_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			// A new sample refills the output register; otherwise it empties
			// once the receiver takes it.
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (tick_go) begin
						state_q <= S_LDIV;
					end
				end
				S_LDIV: begin
					if (!div_busy) begin
						state_q <= use_table_q ? S_RD : S_MA;
					end
				end
				S_RD: state_q <= S_MA;
				S_MA: state_q <= S_MB;
				S_MB: state_q <= S_MW;
				S_MW: state_q <= S_SC;
				S_SC: state_q <= S_FA;
				S_FA: state_q <= S_FB;
				S_FB: state_q <= S_FW;
				S_FW: state_q <= S_FT;
				S_FT: begin
					fs_q    <= target_next;
					state_q <= S_RS;
				end
				S_RS: begin
					state_q <= has_ramp_q ? S_RDIV : S_EMIT;
				end
				S_RDIV: begin
					if (!div_busy) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						sample_q    <= in_ramp ? ramp_next : '0;
						last_q      <= last;
						if (last) begin
							state_q <= S_IDLE;
							if (has_ramp_q) begin
								ramp_q <= fs_q;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			lo_q       <= range_low;
			hd_q       <= {range_high[DW-1], range_high} - {range_low[DW-1], range_low};
			lead_q     <= lead_cw;
			end_q      <= end_cw;
			count_q    <= end_cw - lead_cw;
			has_ramp_q <= lead_cw < end_cw;
		end
		if (state_q == S_LDIV && !div_busy && !use_table_q) begin
			level_q <= signed'(div_quot);
		end
		if (state_q == S_RD) begin
			level_q <= tbl_rdata;
		end
		if (state_q == S_SC) begin
			scaled_q <= scaled_next;
		end
		if (state_q == S_RS) begin
			neg_q      <= diff[DW];
			ramp_acc_q <= ramp_q;
			frac_q     <= '0;
			n_q        <= '0;
		end
		if (state_q == S_RDIV && !div_busy) begin
			step_q     <= div_quot;
			step_rem_q <= div_rem;
		end
		if (emit) begin
			n_q <= n_q + CW'(1);
			if (in_ramp) begin
				ramp_acc_q <= ramp_next;
				frac_q     <= frac_next;
			end
		end
	end

	csr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	csr_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (mac_a),
		.op_b   (mac_b),
		.acc    (mac_acc)
	);

	csr_table #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (waddr_ext[AW-1:0]),
		.wdata (table_data),
		.re    (tbl_re),
		.raddr (div_quot[AW-1:0]),
		.rdata (tbl_rdata)
	);

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign sample      = sample_q;
	assign last_sample = last_q;

	// The divider is only started when it has finished the previous division.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// In the emit phase of a block with a ramp, the ramp fraction stays below the sample count of the ramp.
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && has_ramp_q) |-> (frac_q < csr_pkg::DIV_D_W'(count_q)))
		else $error("ramp fraction out of range");

	// The final ramp sample lands exactly on the new filter output.
	a_ramp_end: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && in_ramp && n_q == end_q - CW'(1)) |=> (sample == fs_q))
		else $error("ramp does not end on the target level");

	// The filter state moves only in the step that writes the new output.
	a_fs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fs_q) |-> ($past(state_q) == S_FT))
		else $error("filter state changed outside its update step");

endmodule
